@@ rtl/core/svpp_pkg.sv @@
// Shared types and constants for the spherical view perspective projection core.
// Used by svpp_xform, svpp_div and the top level; depends on nothing.
package svpp_pkg;

    localparam int CoordW = 32;
    localparam int TrigW  = 16;
    localparam int DistW  = 31;
    localparam int NumW   = 64;
    localparam int MagW   = 63;
    localparam int ProdW  = 94;
    localparam int QuotW  = 34;
    localparam int CfgW   = 32;

    typedef enum logic [2:0] {
        REG_COS_THETA       = 3'd0,
        REG_SIN_THETA       = 3'd1,
        REG_COS_PHI         = 3'd2,
        REG_SIN_PHI         = 3'd3,
        REG_VIEW_DISTANCE   = 3'd4,
        REG_SCREEN_DISTANCE = 3'd5,
        REG_OFFSET_X        = 3'd6,
        REG_OFFSET_Y        = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic signed [TrigW-1:0] cos_theta;
        logic signed [TrigW-1:0] sin_theta;
        logic signed [TrigW-1:0] cos_phi;
        logic signed [TrigW-1:0] sin_phi;
        logic [DistW-1:0]        view_distance;
        logic [DistW-1:0]        screen_distance;
    } xform_cfg_t;

    typedef struct packed {
        logic q_neg;
        logic num_neg;
        logic den_zero;
    } div_tag_t;

endpackage

@@ rtl/core/svpp_xform.sv @@
// View transform pipeline: rotation products, numerators, denominator and
// scaling by the screen distance. Depends on svpp_pkg.
module svpp_xform (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            en,
    input  logic                            in_valid,
    input  logic signed [svpp_pkg::CoordW-1:0] point_x,
    input  logic signed [svpp_pkg::CoordW-1:0] point_y,
    input  logic signed [svpp_pkg::CoordW-1:0] point_z,
    input  svpp_pkg::xform_cfg_t            cfg,
    output logic                            out_valid,
    output logic [svpp_pkg::ProdW-1:0]      prod_x,
    output logic [svpp_pkg::ProdW-1:0]      prod_y,
    output logic [svpp_pkg::MagW-1:0]       den_mag,
    output svpp_pkg::div_tag_t              tag_x,
    output svpp_pkg::div_tag_t              tag_y
);
    import svpp_pkg::*;

    logic [5:0] vld_reg;

    logic signed [31:0] s1_ctsp_reg, s1_stsp_reg, s1_ctcp_reg, s1_stcp_reg;
    logic signed [47:0] s1_cty_reg, s1_stx_reg, s1_cpz_reg, s1_spz_reg;
    logic signed [CoordW-1:0] s1_x_reg, s1_y_reg;

    logic signed [NumW-1:0] s2_denx_reg, s2_deny_reg, s2_nyx_reg, s2_nyy_reg;
    logic signed [48:0] s2_nxp_reg;
    logic signed [47:0] s2_cpz_reg, s2_spz_reg;

    logic signed [NumW-1:0] s3_den_reg, s3_nx_reg, s3_ny_reg;
    logic signed [NumW-1:0] s3_den_next, s3_nx_next, s3_ny_next;

    logic [MagW-1:0] s4_ax_reg, s4_ay_reg, s4_ad_reg;
    div_tag_t s4_tx_reg, s4_ty_reg;

    logic [62:0] s5_xlo_reg, s5_ylo_reg;
    logic [61:0] s5_xhi_reg, s5_yhi_reg;
    logic [MagW-1:0] s5_ad_reg;
    div_tag_t s5_tx_reg, s5_ty_reg;

    logic [ProdW-1:0] s6_px_reg, s6_py_reg;
    logic [MagW-1:0] s6_ad_reg;
    div_tag_t s6_tx_reg, s6_ty_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[4:0], in_valid};
        end
    end

    always_comb begin
        s3_den_next = $signed({5'b0, cfg.view_distance, 28'b0}) - s2_denx_reg - s2_deny_reg
                    - $signed({{2{s2_cpz_reg[47]}}, s2_cpz_reg, 14'b0});
        s3_nx_next  = $signed({s2_nxp_reg[48], s2_nxp_reg, 14'b0});
        s3_ny_next  = s2_nyx_reg + s2_nyy_reg
                    - $signed({{2{s2_spz_reg[47]}}, s2_spz_reg, 14'b0});
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_ctsp_reg <= cfg.cos_theta * cfg.sin_phi;
            s1_stsp_reg <= cfg.sin_theta * cfg.sin_phi;
            s1_ctcp_reg <= cfg.cos_theta * cfg.cos_phi;
            s1_stcp_reg <= cfg.sin_theta * cfg.cos_phi;
            s1_cty_reg  <= cfg.cos_theta * point_y;
            s1_stx_reg  <= cfg.sin_theta * point_x;
            s1_cpz_reg  <= cfg.cos_phi * point_z;
            s1_spz_reg  <= cfg.sin_phi * point_z;
            s1_x_reg    <= point_x;
            s1_y_reg    <= point_y;

            s2_denx_reg <= s1_ctsp_reg * s1_x_reg;
            s2_deny_reg <= s1_stsp_reg * s1_y_reg;
            s2_nyx_reg  <= s1_ctcp_reg * s1_x_reg;
            s2_nyy_reg  <= s1_stcp_reg * s1_y_reg;
            s2_nxp_reg  <= 49'(s1_cty_reg) - 49'(s1_stx_reg);
            s2_cpz_reg  <= s1_cpz_reg;
            s2_spz_reg  <= s1_spz_reg;

            s3_den_reg <= s3_den_next;
            s3_nx_reg  <= s3_nx_next;
            s3_ny_reg  <= s3_ny_next;

            s4_ax_reg <= s3_nx_reg[NumW-1] ? MagW'(-s3_nx_reg) : s3_nx_reg[MagW-1:0];
            s4_ay_reg <= s3_ny_reg[NumW-1] ? MagW'(-s3_ny_reg) : s3_ny_reg[MagW-1:0];
            s4_ad_reg <= s3_den_reg[NumW-1] ? MagW'(-s3_den_reg) : s3_den_reg[MagW-1:0];
            s4_tx_reg <= '{q_neg: s3_nx_reg[NumW-1] ^ s3_den_reg[NumW-1],
                           num_neg: s3_nx_reg[NumW-1], den_zero: (s3_den_reg == '0)};
            s4_ty_reg <= '{q_neg: s3_ny_reg[NumW-1] ^ s3_den_reg[NumW-1],
                           num_neg: s3_ny_reg[NumW-1], den_zero: (s3_den_reg == '0)};

            s5_xlo_reg <= cfg.screen_distance * s4_ax_reg[31:0];
            s5_xhi_reg <= cfg.screen_distance * s4_ax_reg[MagW-1:32];
            s5_ylo_reg <= cfg.screen_distance * s4_ay_reg[31:0];
            s5_yhi_reg <= cfg.screen_distance * s4_ay_reg[MagW-1:32];
            s5_ad_reg  <= s4_ad_reg;
            s5_tx_reg  <= s4_tx_reg;
            s5_ty_reg  <= s4_ty_reg;

            s6_px_reg <= {31'b0, s5_xlo_reg} + {s5_xhi_reg, 32'b0};
            s6_py_reg <= {31'b0, s5_ylo_reg} + {s5_yhi_reg, 32'b0};
            s6_ad_reg <= s5_ad_reg;
            s6_tx_reg <= s5_tx_reg;
            s6_ty_reg <= s5_ty_reg;
        end
    end

    assign out_valid = vld_reg[5];
    assign prod_x    = s6_px_reg;
    assign prod_y    = s6_py_reg;
    assign den_mag   = s6_ad_reg;
    assign tag_x     = s6_tx_reg;
    assign tag_y     = s6_ty_reg;

endmodule

@@ rtl/core/svpp_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
// Depends on svpp_pkg.
module svpp_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [svpp_pkg::ProdW-1:0]  dividend,
    input  logic [svpp_pkg::MagW-1:0]   divisor,
    input  svpp_pkg::div_tag_t          in_tag,
    output logic                        out_valid,
    output logic [svpp_pkg::QuotW-1:0]  quotient,
    output logic                        overflow,
    output svpp_pkg::div_tag_t          out_tag
);
    import svpp_pkg::*;

    localparam int HiW = ProdW - QuotW;

    logic [QuotW:0]    vld_reg;
    logic [MagW-1:0]   rem_reg  [0:QuotW];
    logic [QuotW-1:0]  low_reg  [0:QuotW];
    logic [QuotW-1:0]  quot_reg [0:QuotW];
    logic [MagW-1:0]   den_reg  [0:QuotW];
    logic              ovf_reg  [0:QuotW];
    div_tag_t          tag_reg  [0:QuotW];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[QuotW-1:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0]  <= MagW'(dividend[ProdW-1:QuotW]);
            low_reg[0]  <= dividend[QuotW-1:0];
            quot_reg[0] <= '0;
            den_reg[0]  <= divisor;
            ovf_reg[0]  <= {4'b0, dividend[ProdW-1:QuotW]} >= {{(HiW + 4 - MagW){1'b0}}, divisor};
            tag_reg[0]  <= in_tag;
        end
    end

    for (genvar k = 1; k <= QuotW; k++) begin : g_stage
        logic [MagW:0] trial;
        logic          ge;
        assign trial = {rem_reg[k-1], low_reg[k-1][QuotW-1]};
        assign ge    = trial >= {1'b0, den_reg[k-1]};

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k]  <= ge ? MagW'(trial - {1'b0, den_reg[k-1]}) : trial[MagW-1:0];
                low_reg[k]  <= {low_reg[k-1][QuotW-2:0], 1'b0};
                quot_reg[k] <= {quot_reg[k-1][QuotW-2:0], ge};
                den_reg[k]  <= den_reg[k-1];
                ovf_reg[k]  <= ovf_reg[k-1];
                tag_reg[k]  <= tag_reg[k-1];
            end
        end
    end

    assign out_valid = vld_reg[QuotW];
    assign quotient  = quot_reg[QuotW];
    assign overflow  = ovf_reg[QuotW];
    assign out_tag   = tag_reg[QuotW];

endmodule

@@ rtl/core/spherical_view_perspective_project_core.sv @@
// Top level of the spherical view perspective projection core: registers,
// transform pipeline, two dividers and the saturating output stage.
// Depends on svpp_pkg, svpp_xform and svpp_div.
//
//  Channel  Direction  Payload
//  s_       in         tdata: point_x, point_y, point_z
//  m_       out        tdata: screen_x, screen_y; tuser: depth_fault
//  cfg_     in         register index and write data, no read-back
//
// One point enters per cycle while the output is not stalled; its result passes
// through the six transform stages, the 35 divider stages and the output register.
// Reset is synchronous, clears the valid bits and loads the configuration defaults.
// A stalled output freezes the whole pipeline; nothing is lost or repeated.
module spherical_view_perspective_project_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // point_x, point_y, point_z
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // screen_x, screen_y
    output logic        m_tuser,   // depth_fault
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_wdata
);
    import svpp_pkg::*;

    xform_cfg_t         cfg_reg;
    logic signed [31:0] offset_x_reg, offset_y_reg;

    logic en;
    logic xf_valid;
    logic [ProdW-1:0] prod_x, prod_y;
    logic [MagW-1:0]  den_mag;
    div_tag_t tag_x, tag_y, dtag_x, dtag_y;
    logic dx_valid, dy_valid, ovf_x, ovf_y;
    logic [QuotW-1:0] quot_x, quot_y;

    logic        m_tvalid_reg;
    logic [31:0] screen_x_reg, screen_y_reg, screen_x_next, screen_y_next;
    logic        fault_reg;

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.cos_theta       <= 16'sd16384;
            cfg_reg.sin_theta       <= '0;
            cfg_reg.cos_phi         <= 16'sd16384;
            cfg_reg.sin_phi         <= '0;
            cfg_reg.view_distance   <= 31'd655360;
            cfg_reg.screen_distance <= 31'd65536;
            offset_x_reg            <= '0;
            offset_y_reg            <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index_t'(cfg_index))
                REG_COS_THETA:       cfg_reg.cos_theta       <= cfg_wdata[15:0];
                REG_SIN_THETA:       cfg_reg.sin_theta       <= cfg_wdata[15:0];
                REG_COS_PHI:         cfg_reg.cos_phi         <= cfg_wdata[15:0];
                REG_SIN_PHI:         cfg_reg.sin_phi         <= cfg_wdata[15:0];
                REG_VIEW_DISTANCE:   cfg_reg.view_distance   <= cfg_wdata[30:0];
                REG_SCREEN_DISTANCE: cfg_reg.screen_distance <= cfg_wdata[30:0];
                REG_OFFSET_X:        offset_x_reg            <= cfg_wdata;
                REG_OFFSET_Y:        offset_y_reg            <= cfg_wdata;
                default: ;
            endcase
        end
    end

    svpp_xform u_xform (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid),
        .point_x   (s_tdata[31:0]),
        .point_y   (s_tdata[63:32]),
        .point_z   (s_tdata[95:64]),
        .cfg       (cfg_reg),
        .out_valid (xf_valid),
        .prod_x    (prod_x),
        .prod_y    (prod_y),
        .den_mag   (den_mag),
        .tag_x     (tag_x),
        .tag_y     (tag_y)
    );

    svpp_div u_div_x (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (xf_valid),
        .dividend  (prod_x),
        .divisor   (den_mag),
        .in_tag    (tag_x),
        .out_valid (dx_valid),
        .quotient  (quot_x),
        .overflow  (ovf_x),
        .out_tag   (dtag_x)
    );

    svpp_div u_div_y (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (xf_valid),
        .dividend  (prod_y),
        .divisor   (den_mag),
        .in_tag    (tag_y),
        .out_valid (dy_valid),
        .quotient  (quot_y),
        .overflow  (ovf_y),
        .out_tag   (dtag_y)
    );

    function automatic logic [31:0] finish(input logic [QuotW-1:0] q, input logic ovf,
                                           input div_tag_t tag, input logic signed [31:0] off);
        logic signed [QuotW+2:0] mag;
        logic signed [QuotW+2:0] sum;
        logic [31:0] res;
        mag = ovf ? $signed({3'b001, {QuotW{1'b0}}}) : $signed({3'b000, q});
        sum = (tag.q_neg ? -mag : mag) + (QuotW+3)'(off);
        if (tag.den_zero) begin
            res = tag.num_neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else if (sum[QuotW+2:31] == '0 || sum[QuotW+2:31] == '1) begin
            res = sum[31:0];
        end else begin
            res = sum[QuotW+2] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        return res;
    endfunction

    assign screen_x_next = finish(quot_x, ovf_x, dtag_x, offset_x_reg);
    assign screen_y_next = finish(quot_y, ovf_y, dtag_y, offset_y_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= dx_valid && dy_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            screen_x_reg <= screen_x_next;
            screen_y_reg <= screen_y_next;
            fault_reg    <= dtag_x.den_zero;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {screen_y_reg, screen_x_reg};
    assign m_tuser  = fault_reg;

endmodule

@@ verif/spherical_view_perspective_project_core_test.sv @@
// Self-checking testbench for the spherical view perspective projection core.
// Streams 3D points with random handshake gaps and compares every screen result
// against a local fixed-point predictor. Depends on svpp_pkg and the core RTL.
module spherical_view_perspective_project_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import svpp_pkg::*;

    typedef struct packed {
        logic        fault;
        logic [31:0] sy;
        logic [31:0] sx;
    } proj_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [95:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;
    logic        m_tuser;
    logic        cfg_wr_en;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_wdata;

    logic signed [15:0] v_ct, v_st, v_cp, v_sp;
    logic [30:0]        v_rho, v_d;
    logic signed [31:0] v_offx, v_offy;

    proj_t       pending_proj[$];
    int          mismatches;
    longint      cycles;
    int          hold_off;
    bit          stall_random;

    spherical_view_perspective_project_core dut (.*);

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > 4000000) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        mismatches++;
    endtask

    function automatic logic [31:0] scale_coord(input logic signed [63:0] num,
                                                input logic signed [63:0] den,
                                                input logic signed [31:0] off);
        logic [127:0]        prod;
        logic [127:0]        q;
        logic [63:0]         anum, aden;
        logic signed [127:0] v;
        anum = num[63] ? -num : num;
        aden = den[63] ? -den : den;
        prod = {64'd0, anum} * {97'd0, v_d};
        q = prod / {64'd0, aden};
        if (q > (128'd1 << 40)) q = 128'd1 << 40;
        v = $signed(q);
        if (num[63] != den[63]) v = -v;
        v = v + off;
        if (v > 128'sh7FFFFFFF) v = 128'sh7FFFFFFF;
        if (v < -128'sh80000000) v = -128'sh80000000;
        return v[31:0];
    endfunction

    function automatic proj_t project_point(input logic [95:0] p);
        logic signed [63:0] x, y, z, ct, st, cp, sp, den, nx, ny;
        proj_t r;
        x = $signed(p[31:0]);
        y = $signed(p[63:32]);
        z = $signed(p[95:64]);
        ct = v_ct; st = v_st; cp = v_cp; sp = v_sp;
        den = $signed({33'd0, v_rho}) <<< 28;
        den = den - ct * sp * x - st * sp * y - cp * z * 64'sd16384;
        nx = (ct * y - st * x) * 64'sd16384;
        ny = ct * cp * x + st * cp * y - sp * z * 64'sd16384;
        if (den == 0) begin
            r.sx = nx[63] ? 32'h80000000 : 32'h7FFFFFFF;
            r.sy = ny[63] ? 32'h80000000 : 32'h7FFFFFFF;
            r.fault = 1'b1;
        end else begin
            r.sx = scale_coord(nx, den, v_offx);
            r.sy = scale_coord(ny, den, v_offy);
            r.fault = 1'b0;
        end
        return r;
    endfunction

    // Receiver: random stalls, a long counted hold-off when requested, or always ready.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_tready <= 1'b0;
        end else if (stall_random) begin
            if ($urandom_range(0, 99) < 70) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b0;
                if ($urandom_range(0, 19) == 0) hold_off <= $urandom_range(5, 40);
            end
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        proj_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_proj.size() == 0) begin
                report_mismatch("unexpected result", m_tdata[31:0], 32'd0);
            end else begin
                want = pending_proj.pop_front();
                if (m_tdata[31:0] !== want.sx)
                    report_mismatch("screen_x", m_tdata[31:0], want.sx);
                if (m_tdata[63:32] !== want.sy)
                    report_mismatch("screen_y", m_tdata[63:32], want.sy);
                if (m_tuser !== want.fault)
                    report_mismatch("depth_fault", {31'd0, m_tuser}, {31'd0, want.fault});
            end
        end
    end

    task automatic send_point(input logic [95:0] p, input bit gaps);
        int gap;
        gap = 0;
        if (gaps) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40)
                                               : $urandom_range(0, 2);
            if ($urandom_range(0, 1) == 0) gap = 0;
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata  <= p;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        pending_proj.push_back(project_point(p));
        @(negedge aclk);
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        while (pending_proj.size() != 0) @(negedge aclk);
        repeat (60) @(negedge aclk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [31:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_COS_THETA:       v_ct = val[15:0];
            REG_SIN_THETA:       v_st = val[15:0];
            REG_COS_PHI:         v_cp = val[15:0];
            REG_SIN_PHI:         v_sp = val[15:0];
            REG_VIEW_DISTANCE:   v_rho = val[30:0];
            REG_SCREEN_DISTANCE: v_d = val[30:0];
            REG_OFFSET_X:        v_offx = val;
            REG_OFFSET_Y:        v_offy = val;
            default: ;
        endcase
        @(negedge aclk);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'h80000000 | ($urandom_range(0, 3));
            2: return 32'h7FFFFFFF - $urandom_range(0, 3);
            default: return $signed($urandom_range(0, 20 << 16)) - (10 << 16);
        endcase
    endfunction

    function automatic logic [15:0] rand_trig();
        case ($urandom_range(0, 5))
            0: return 16'($urandom);
            1: return 16'sd16384;
            2: return -16'sd16384;
            default: return 16'($signed($urandom_range(0, 32768)) - 16384);
        endcase
    endfunction

    task automatic test_directed;
        logic [31:0] ext[6];
        ext = '{32'h0, 32'h7FFFFFFF, 32'h80000000, 32'h00010000, 32'hFFFF0000, 32'h000A0000};
        foreach (ext[i]) send_point({ext[i], ext[(i + 1) % 6], ext[(i + 2) % 6]}, 1'b0);
        // Depth equal to the view distance gives a zero denominator.
        send_point({32'h000A0000, 32'h00010000, 32'h0}, 1'b0);
        send_point({32'h000A0000, 32'hFFFF0000, 32'hFFFF0000}, 1'b0);
        send_point({32'h000A0000, 32'h0, 32'h0}, 1'b0);
        // Points behind the viewer and far beyond it.
        send_point({32'h00140000, 32'h00030000, 32'h00020000}, 1'b0);
        send_point({32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000}, 1'b0);
        drain();
    endtask

    task automatic test_config_extremes;
        write_reg(REG_COS_THETA, 32'h8000);
        write_reg(REG_SIN_THETA, 32'h7FFF);
        write_reg(REG_COS_PHI, -32'sd16384);
        write_reg(REG_SIN_PHI, 32'sd16384);
        write_reg(REG_VIEW_DISTANCE, 32'h7FFFFFFF);
        write_reg(REG_SCREEN_DISTANCE, 32'h7FFFFFFF);
        write_reg(REG_OFFSET_X, 32'h7FFFFFFF);
        write_reg(REG_OFFSET_Y, 32'h80000000);
        for (int i = 0; i < 10; i++) send_point({rand_coord(), rand_coord(), rand_coord()}, 1'b1);
        drain();
        write_reg(REG_VIEW_DISTANCE, 32'h0);
        write_reg(REG_SCREEN_DISTANCE, 32'h0);
        write_reg(REG_OFFSET_X, 32'h0);
        write_reg(REG_OFFSET_Y, 32'h0);
        send_point(96'h0, 1'b0);
        for (int i = 0; i < 10; i++) send_point({rand_coord(), rand_coord(), rand_coord()}, 1'b1);
        drain();
    endtask

    task automatic test_random_views;
        for (int phase = 0; phase < 16; phase++) begin
            write_reg(REG_COS_THETA, {16'd0, rand_trig()});
            write_reg(REG_SIN_THETA, {16'd0, rand_trig()});
            write_reg(REG_COS_PHI, {16'd0, rand_trig()});
            write_reg(REG_SIN_PHI, {16'd0, rand_trig()});
            write_reg(REG_VIEW_DISTANCE, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 50 << 16));
            write_reg(REG_SCREEN_DISTANCE, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 4 << 16));
            write_reg(REG_OFFSET_X, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 1 << 20));
            write_reg(REG_OFFSET_Y, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 1 << 20));
            stall_random = (phase % 4) != 3;
            for (int i = 0; i < 95; i++)
                send_point({rand_coord(), rand_coord(), rand_coord()}, stall_random);
            drain();
        end
        stall_random = 1'b1;
    endtask

    task automatic test_backpressure;
        hold_off = 300;
        for (int i = 0; i < 80; i++) send_point({rand_coord(), rand_coord(), rand_coord()}, 1'b0);
        drain();
    endtask

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_wr_en = 1'b0;
        cfg_index = REG_COS_THETA;
        cfg_wdata = '0;
        mismatches = 0;
        cycles = 0;
        hold_off = 0;
        stall_random = 1'b1;
        v_ct = 16'sd16384; v_st = 0; v_cp = 16'sd16384; v_sp = 0;
        v_rho = 31'd655360; v_d = 31'd65536; v_offx = 0; v_offy = 0;
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_directed();
        test_config_extremes();
        test_backpressure();
        test_random_views();
        drain();
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
